// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the duration parser.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define DSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/core/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg
// Types, character codes, unit codes and unit factors shared by the duration
// text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TOTAL_W  = 31;
  localparam int unsigned FACTOR_W = 27;
  localparam int unsigned PROG_W   = 3;
  localparam int unsigned ADDR_W   = 2;

  localparam logic [TOTAL_W-1:0] SAT_MAX = '1;

  // Unit order; a new unit must be strictly above the last one taken.
  localparam logic [PROG_W-1:0] PROG_NONE    = 3'd0;
  localparam logic [PROG_W-1:0] PROG_DAYS    = 3'd1;
  localparam logic [PROG_W-1:0] PROG_HOURS   = 3'd2;
  localparam logic [PROG_W-1:0] PROG_MINUTES = 3'd3;
  localparam logic [PROG_W-1:0] PROG_SECONDS = 3'd4;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_D  = 8'h44;
  localparam logic [CHAR_W-1:0] CH_UP_H  = 8'h48;
  localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_UP_S  = 8'h53;
  localparam logic [CHAR_W-1:0] CH_LO_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
  localparam logic [CHAR_W-1:0] CH_LO_M  = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_LO_S  = 8'h73;

  localparam logic [ADDR_W-1:0] REG_MODE_ADDR = 2'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_time;
    logic               format_error;
    logic               saturated;
  } result_t;

  function automatic logic [FACTOR_W-1:0] unit_factor(input logic ms,
                                                      input logic [PROG_W-1:0] unit);
    logic [FACTOR_W-1:0] f;
    f = '0;
    case (unit)
      PROG_DAYS:    f = ms ? 27'd86400000 : 27'd86400;
      PROG_HOURS:   f = ms ? 27'd3600000  : 27'd3600;
      PROG_MINUTES: f = ms ? 27'd60000    : 27'd60;
      PROG_SECONDS: f = ms ? 27'd1000     : 27'd1;
      default:      f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsp_in_stage.sv -----
// ----------------------------------------------------------------------------
// dsp_in_stage
// Input register of the parser. Holds one item and hands it to the step logic
// as soon as the result side has room for what it may produce.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire dsp_pkg::item_t  s_item,
  input  wire logic            out_space,
  output logic                 fire,
  output dsp_pkg::item_t       item
);

  logic           valid;
  logic           valid_next;
  logic           accept;

  // A non-last item never produces a result, so it needs no room downstream.
  assign fire     = valid && (!item.last_char || out_space);
  assign s_tready = !valid || fire;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next = 1'b1;
    end else if (fire) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsp_step.sv -----
// ----------------------------------------------------------------------------
// dsp_step
// Parser state and the per-character update: decimal field build, unit close
// with a constant factor, saturation, order and format checks, end of text.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              millisecond_mode,
  input  wire logic              fire,
  input  wire dsp_pkg::item_t    item,
  output logic                   res_valid,
  output dsp_pkg::result_t       res
);

  localparam int unsigned TW = dsp_pkg::TOTAL_W;
  localparam int unsigned FW = dsp_pkg::FACTOR_W;
  localparam int unsigned PW = dsp_pkg::PROG_W;

  logic [PW-1:0]    unit_progress;
  logic [TW-1:0]    field_value;
  logic             field_present;
  logic [TW-1:0]    running_total;
  logic             error_seen;
  logic             overflow_seen;

  logic [PW-1:0]    unit_progress_next;
  logic [TW-1:0]    field_value_next;
  logic             field_present_next;
  logic [TW-1:0]    running_total_next;
  logic             error_seen_next;
  logic             overflow_seen_next;

  logic [dsp_pkg::CHAR_W-1:0] c;
  logic             is_digit;
  logic             is_ws;
  logic             is_unit;
  logic [PW-1:0]    char_unit;
  logic [TW+3:0]    v_wide;
  logic             v_ovf;
  logic [TW-1:0]    v_sat;
  logic             active;
  logic             do_close;
  logic [PW-1:0]    close_unit;
  logic [TW-1:0]    op_val;
  logic             op_present;
  logic             close_bad;
  logic [FW-1:0]    factor;
  logic [TW+FW-1:0] prod;
  logic             prod_ovf;
  logic [TW-1:0]    prod_sat;
  logic [TW:0]      sum;
  logic             sum_ovf;
  logic [TW-1:0]    sum_sat;

  assign c        = item.char_code;
  assign is_digit = (c inside {[dsp_pkg::CH_ZERO:dsp_pkg::CH_NINE]});

  always_comb begin
    char_unit = dsp_pkg::PROG_NONE;
    is_ws     = 1'b0;
    case (c)
      dsp_pkg::CH_SPACE, dsp_pkg::CH_TAB: is_ws     = 1'b1;
      dsp_pkg::CH_UP_D,  dsp_pkg::CH_LO_D: char_unit = dsp_pkg::PROG_DAYS;
      dsp_pkg::CH_UP_H,  dsp_pkg::CH_LO_H: char_unit = dsp_pkg::PROG_HOURS;
      dsp_pkg::CH_UP_M,  dsp_pkg::CH_LO_M: char_unit = dsp_pkg::PROG_MINUTES;
      dsp_pkg::CH_UP_S,  dsp_pkg::CH_LO_S: char_unit = dsp_pkg::PROG_SECONDS;
      default: begin
        char_unit = dsp_pkg::PROG_NONE;
        is_ws     = 1'b0;
      end
    endcase
  end

  assign is_unit = (char_unit != dsp_pkg::PROG_NONE);

  // field * 10 + digit as two shifts and two adds.
  assign v_wide = ({4'b0, field_value} << 3) + ({4'b0, field_value} << 1)
                + {{(TW){1'b0}}, c[3:0]};
  assign v_ovf  = |v_wide[TW+3:TW];
  assign v_sat  = v_ovf ? dsp_pkg::SAT_MAX : v_wide[TW-1:0];

  // At most one field closes per character: a unit or whitespace closes the
  // pending field, and a digit on the last character closes its own field.
  assign active     = !error_seen;
  assign do_close   = active && (is_unit || (is_ws && field_present)
                                 || (is_digit && item.last_char));
  assign close_unit = (is_digit || is_ws) ? dsp_pkg::PROG_SECONDS : char_unit;
  assign op_val     = is_digit ? v_sat : field_value;
  assign op_present = is_digit || field_present;
  assign close_bad  = !op_present || (unit_progress >= close_unit);

  assign factor   = dsp_pkg::unit_factor(millisecond_mode, close_unit);
  assign prod     = {{(FW){1'b0}}, op_val} * {{(TW){1'b0}}, factor};
  assign prod_ovf = |prod[TW+FW-1:TW];
  assign prod_sat = prod_ovf ? dsp_pkg::SAT_MAX : prod[TW-1:0];
  assign sum      = {1'b0, running_total} + {1'b0, prod_sat};
  assign sum_ovf  = sum[TW];
  assign sum_sat  = sum_ovf ? dsp_pkg::SAT_MAX : sum[TW-1:0];

  always_comb begin
    unit_progress_next = unit_progress;
    field_value_next   = field_value;
    field_present_next = field_present;
    running_total_next = running_total;
    error_seen_next    = error_seen;
    overflow_seen_next = overflow_seen;
    if (active) begin
      if (is_digit) begin
        field_value_next   = v_sat;
        field_present_next = 1'b1;
        overflow_seen_next = overflow_seen || v_ovf;
      end else if (!is_unit && !is_ws) begin
        error_seen_next = 1'b1;
      end
    end
    if (do_close) begin
      if (close_bad) begin
        error_seen_next = 1'b1;
      end else begin
        unit_progress_next = close_unit;
        field_value_next   = '0;
        field_present_next = 1'b0;
        running_total_next = sum_sat;
        overflow_seen_next = overflow_seen_next || prod_ovf || sum_ovf;
      end
    end
  end

  assign res_valid        = fire && item.last_char;
  assign res.total_time   = error_seen_next ? '0 : running_total_next;
  assign res.format_error = error_seen_next;
  assign res.saturated    = !error_seen_next && overflow_seen_next;

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_char)) begin
      unit_progress <= dsp_pkg::PROG_NONE;
      field_value   <= '0;
      field_present <= 1'b0;
      running_total <= '0;
      error_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      unit_progress <= unit_progress_next;
      field_value   <= field_value_next;
      field_present <= field_present_next;
      running_total <= running_total_next;
      error_seen    <= error_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsp_out_skid.sv -----
// ----------------------------------------------------------------------------
// dsp_out_skid
// Result register with one spare entry. Room for a new result is a registered
// signal, so a stall on the output never reaches the input handshake within
// the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_out_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dsp_pkg::result_t  push_data,
  output logic                   space,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output dsp_pkg::result_t       m_data
);

  logic              out_valid;
  logic              out_valid_next;
  logic              skid_valid;
  logic              skid_valid_next;
  dsp_pkg::result_t  skid_data;
  logic              main_load;
  logic              main_from_skid;
  logic              skid_load;

  assign m_tvalid = out_valid;
  assign space    = !skid_valid;

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    main_load       = 1'b0;
    main_from_skid  = 1'b0;
    skid_load       = 1'b0;
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        main_load       = 1'b1;
        main_from_skid  = 1'b1;
        out_valid_next  = 1'b1;
        skid_valid_next = 1'b0;
      end else begin
        main_load      = push;
        out_valid_next = push;
      end
    end else if (push) begin
      skid_load       = 1'b1;
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      m_data <= main_from_skid ? skid_data : push_data;
    end
    if (skid_load) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/duration_string_parser.sv -----
// ----------------------------------------------------------------------------
// duration_string_parser
// Parses a duration text such as "2d 3h 15m 10", one character per item, and
// gives its total in seconds or milliseconds when the last character arrives.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[7:0] char_code, s_tlast last_char
// m_*      out  m_tvalid/m_tready  m_tdata[30:0] total_time,
//                                  m_tuser[0] format_error, m_tuser[1] saturated
// APB      in   psel/penable/pready  0x0 millisecond_mode (bit 0)
//
// One character is taken every cycle while no last character waits for room;
// the step logic finishes each character in the cycle it leaves the input
// register, through one constant-factor multiplier and one add. A result is
// registered in the result register. Reset is synchronous and clears all
// parser state and the mode register. An output stall fills the spare result
// entry, after which a last character waits in the input register for room.
// ----------------------------------------------------------------------------
`default_nettype none

module duration_string_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [30:0] total_time, [31] zero
  output logic [1:0]       m_tuser,   // [0] format_error, [1] saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              millisecond_mode;
  dsp_pkg::item_t    s_item;
  dsp_pkg::item_t    item;
  logic              fire;
  logic              out_space;
  logic              res_valid;
  dsp_pkg::result_t  res;
  dsp_pkg::result_t  m_data;

  assign pready = 1'b1;
  assign prdata = {31'b0, millisecond_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      millisecond_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr == dsp_pkg::REG_MODE_ADDR)) begin
      millisecond_mode <= pwdata[0];
    end
  end

  assign s_item.char_code = s_tdata;
  assign s_item.last_char = s_tlast;

  dsp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_item    (s_item),
    .out_space (out_space),
    .fire      (fire),
    .item      (item)
  );

  dsp_step u_step (
    .clk              (clk),
    .rst              (rst),
    .millisecond_mode (millisecond_mode),
    .fire             (fire),
    .item             (item),
    .res_valid        (res_valid),
    .res              (res)
  );

  dsp_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (out_space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (m_data)
  );

  assign m_tdata = {1'b0, m_data.total_time};
  assign m_tuser = {m_data.saturated, m_data.format_error};

endmodule

`default_nettype wire

// ----- rtl/core/dsp_checker.sv -----
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks for the duration parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [1:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // After reset the parser is empty and takes an item at once.
  `DSP_ASSERT_ALWAYS(a_reset_empty, rst |=> (s_tready && !m_tvalid), "not empty after reset")

  // A stalled result holds its value.
  `DSP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed under stall")

  // An error result carries a zero total and no saturation flag.
  `DSP_ASSERT(a_err_zero, (m_tvalid && m_tuser[0]) |-> ((m_tdata == 32'd0) && !m_tuser[1]), "error result not cleared")

  // A mode write reads back on the next cycle.
  `DSP_ASSERT(a_mode_write, (psel && penable && pwrite && pready && (paddr == dsp_pkg::REG_MODE_ADDR)) |=> (prdata[0] == $past(pwdata[0])), "mode write lost")

endmodule

bind duration_string_parser dsp_checker u_dsp_checker (.*);

`default_nettype wire
